/* rtl/assert_macros.svh */
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold in the same cycle as its trigger
`define ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// property whose consequence is checked in the cycle after its trigger
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/brd_pkg.sv */
// shared types and codes of the bitmap run-length pixel decoder
package brd_pkg;

    // status codes of a result transaction
    localparam logic [1:0] ST_RUN   = 2'd0;
    localparam logic [1:0] ST_EOB   = 2'd1;
    localparam logic [1:0] ST_DELTA = 2'd2;
    localparam logic [1:0] ST_TRUNC = 2'd3;

    // second byte of an escape pair
    localparam logic [7:0] ESC_EOL   = 8'd0;
    localparam logic [7:0] ESC_EOB   = 8'd1;
    localparam logic [7:0] ESC_DELTA = 8'd2;

    typedef struct packed {
        logic [7:0] code_byte;
        logic       final_byte;
    } brd_in_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] line_number;
        logic [15:0] start_column;
        logic [7:0]  pixel_count;
        logic [7:0]  even_color;
        logic [7:0]  odd_color;
    } brd_out_t;

    // one byte handed to the decode stage
    typedef struct packed {
        logic    fire;
        logic    nibble_mode;
        brd_in_t item;
    } brd_step_t;

    // what the decode stage gives for that byte
    typedef struct packed {
        logic     emit;
        brd_out_t data;
    } brd_res_t;

endpackage

/* rtl/brd_decode.sv */
// decode state and next-state logic for one compressed byte
module brd_decode #(
    parameter int COUNTER_BITS = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  brd_pkg::brd_step_t step,
    output brd_pkg::brd_res_t  res
);
    import brd_pkg::*;

    localparam int CB = COUNTER_BITS;
    localparam int OW = (COUNTER_BITS > 16) ? COUNTER_BITS : 16;

    typedef enum logic [3:0] {
        PH_FIRST  = 4'b0001,
        PH_SECOND = 4'b0010,
        PH_ABS    = 4'b0100,
        PH_PAD    = 4'b1000
    } phase_t;

    phase_t          phase_reg, phase_next;
    logic [7:0]      hold_reg, hold_next;
    logic [7:0]      abs_left_reg, abs_left_next;
    logic [1:0]      pad_left_reg, pad_left_next;
    logic [CB-1:0]   line_reg, line_next;
    logic [CB-1:0]   col_reg, col_next;
    logic            stopped_reg, stopped_next;

    logic [7:0]      b;
    logic [7:0]      ev_color, od_color;
    logic [8:0]      abs_bytes;
    logic [7:0]      abs_step;
    logic [7:0]      abs_rem;
    logic [1:0]      pad_rem;
    logic [OW-1:0]   line_ext, col_ext;

    // saturating add of a byte-wide step
    function automatic logic [CB-1:0] sat_add(input logic [CB-1:0] a, input logic [7:0] n);
        logic [CB:0] s;
        s = {1'b0, a} + (CB + 1)'(n);
        return s[CB] ? {CB{1'b1}} : s[CB-1:0];
    endfunction

    assign b         = step.item.code_byte;
    assign ev_color  = step.nibble_mode ? {4'd0, b[7:4]} : b;
    assign od_color  = step.nibble_mode ? {4'd0, b[3:0]} : b;
    assign abs_bytes = ({1'b0, b} + 9'd1) >> 1;
    assign abs_step  = (!step.nibble_mode) ? 8'd1 :
                       (abs_left_reg >= 8'd2) ? 8'd2 : abs_left_reg;
    assign abs_rem   = abs_left_reg - abs_step;
    assign pad_rem   = (pad_left_reg != 2'd0) ? pad_left_reg - 2'd1 : pad_left_reg;
    assign line_ext  = OW'(line_reg);
    assign col_ext   = OW'(col_reg);

    always_comb begin
        phase_next    = phase_reg;
        hold_next     = hold_reg;
        abs_left_next = abs_left_reg;
        pad_left_next = pad_left_reg;
        line_next     = line_reg;
        col_next      = col_reg;
        stopped_next  = stopped_reg;

        res                   = '0;
        res.data.line_number  = line_ext[15:0];
        res.data.start_column = col_ext[15:0];

        if (step.fire && !stopped_reg) begin
            if (phase_reg == PH_SECOND && hold_reg == 8'd0 &&
                (b == ESC_EOB || b == ESC_DELTA)) begin
                stopped_next    = 1'b1;
                res.emit        = 1'b1;
                res.data.status = (b == ESC_EOB) ? ST_EOB : ST_DELTA;
            end else if (step.item.final_byte) begin
                stopped_next    = 1'b1;
                res.emit        = 1'b1;
                res.data.status = ST_TRUNC;
            end else begin
                unique case (phase_reg)
                    PH_FIRST: begin
                        hold_next  = b;
                        phase_next = PH_SECOND;
                    end
                    PH_SECOND: begin
                        phase_next = PH_FIRST;
                        if (hold_reg != 8'd0) begin
                            // encoded run
                            col_next             = sat_add(col_reg, hold_reg);
                            res.emit             = 1'b1;
                            res.data.status      = ST_RUN;
                            res.data.pixel_count = hold_reg;
                            res.data.even_color  = ev_color;
                            res.data.odd_color   = od_color;
                        end else if (b == ESC_EOL) begin
                            line_next = sat_add(line_reg, 8'd1);
                            col_next  = '0;
                        end else begin
                            // absolute run, padded to a whole word
                            abs_left_next = b;
                            pad_left_next = step.nibble_mode ? {1'b0, abs_bytes[0]}
                                                             : {1'b0, b[0]};
                            phase_next    = PH_ABS;
                        end
                    end
                    PH_ABS: begin
                        if (abs_left_reg == 8'd0) begin
                            phase_next = (pad_left_reg != 2'd0) ? PH_PAD : PH_FIRST;
                        end else begin
                            res.emit             = 1'b1;
                            res.data.status      = ST_RUN;
                            res.data.pixel_count = abs_step;
                            res.data.even_color  = ev_color;
                            res.data.odd_color   = od_color;
                            abs_left_next        = abs_rem;
                            col_next             = sat_add(col_reg, abs_step);
                            if (abs_rem == 8'd0) begin
                                phase_next = (pad_left_reg != 2'd0) ? PH_PAD : PH_FIRST;
                            end
                        end
                    end
                    PH_PAD: begin
                        pad_left_next = pad_rem;
                        if (pad_rem == 2'd0) begin
                            phase_next = PH_FIRST;
                        end
                    end
                    default: begin
                        phase_next = PH_FIRST;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_FIRST;
            hold_reg     <= '0;
            abs_left_reg <= '0;
            pad_left_reg <= '0;
            line_reg     <= '0;
            col_reg      <= '0;
            stopped_reg  <= 1'b0;
        end else begin
            phase_reg    <= phase_next;
            hold_reg     <= hold_next;
            abs_left_reg <= abs_left_next;
            pad_left_reg <= pad_left_next;
            line_reg     <= line_next;
            col_reg      <= col_next;
            stopped_reg  <= stopped_next;
        end
    end

endmodule

/* rtl/bmp_rle_pixel_decoder.sv */
// top level of the bitmap run-length pixel decoder
//
// decodes 8-bit or 4-bit run-length compressed bitmap data, one compressed byte
// per input transaction; nibble_mode (cfg_wdata, written with cfg_we) picks the
// 4-bit coding when set and should only change while the block is idle.
// each byte gives at most one result transaction: an encoded pair gives one run
// of alternating colours, each absolute data byte gives a run of one or two
// pixels, word padding and end of line give nothing, and end of bitmap, delta
// and a truncated stream give a status result after which all bytes are dropped
// until reset. line and column counters are COUNTER_BITS wide and saturate; the
// result carries their low 16 bits.
// throughput is one byte per clock when the result side keeps up; a byte passes
// through the input register, then its decode goes into the result register. the
// rate is set by the decode state, which is read and updated once per byte. a full
// result register stalls the input register, and s_ready then follows m_ready.
module bmp_rle_pixel_decoder #(
    parameter int COUNTER_BITS = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    // configuration
    input  logic              cfg_we,
    input  logic              cfg_wdata,
    // compressed byte stream
    input  logic              s_valid,
    output logic              s_ready,
    input  brd_pkg::brd_in_t  s_data,
    // decoded runs and status
    output logic              m_valid,
    input  logic              m_ready,
    output brd_pkg::brd_out_t m_data
);
    import brd_pkg::*;

    logic      nibble_mode_reg;
    logic      in_valid_reg;
    brd_in_t   in_data_reg;
    logic      m_valid_reg;
    brd_out_t  m_data_reg;

    logic      fire;
    brd_step_t step;
    brd_res_t  res;

    // the held byte moves on when the result register is free or being drained
    assign fire    = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || fire;

    assign step.fire        = fire;
    assign step.nibble_mode = nibble_mode_reg;
    assign step.item        = in_data_reg;

    brd_decode #(
        .COUNTER_BITS(COUNTER_BITS)
    ) u_decode (
        .aclk   (aclk),
        .aresetn(aresetn),
        .step   (step),
        .res    (res)
    );

    // mode register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nibble_mode_reg <= 1'b0;
        end else if (cfg_we) begin
            nibble_mode_reg <= cfg_wdata;
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
    end

    // result register; a byte with no result leaves it empty
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (fire) begin
            m_valid_reg <= res.emit;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire && res.emit) begin
            m_data_reg <= res.data;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

/* rtl/brd_checker.sv */
// port-level checks of the bitmap run-length pixel decoder and its bind
`include "assert_macros.svh"

module brd_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              m_valid,
    input logic              m_ready,
    input brd_pkg::brd_out_t m_data
);
    import brd_pkg::*;

    // a stalled result holds
    `ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data), "result changed while stalled")

    // nothing follows a status result
    `ASSERT_NEXT(a_stop_final, aclk, aresetn, m_valid && m_ready && m_data.status != ST_RUN, !m_valid, "result after stop")

    // status results carry no pixels
    `ASSERT_SAME(a_status_empty, aclk, aresetn, m_valid && m_data.status != ST_RUN, m_data.pixel_count == 8'd0 && m_data.even_color == 8'd0 && m_data.odd_color == 8'd0, "status result with pixel data")

    // a run always has pixels
    `ASSERT_SAME(a_run_nonempty, aclk, aresetn, m_valid && m_data.status == ST_RUN, m_data.pixel_count != 8'd0, "empty pixel run")

endmodule

bind bmp_rle_pixel_decoder brd_checker u_brd_checker (
    .aclk   (aclk),
    .aresetn(aresetn),
    .m_valid(m_valid),
    .m_ready(m_ready),
    .m_data (m_data)
);
